// ----- src/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam logic [15:0] ERR_WORD  = 16'h003F;
    localparam logic [5:0]  HI_SURR   = 6'b110110;
    localparam logic [5:0]  LO_SURR   = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h010000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One queue entry: the one or two result beats caused by one input byte.
    typedef struct packed {
        logic [15:0] word0;
        logic [15:0] word1;
        logic        valid0;
        logic        two;
        logic        eos;
    } entry_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ----- src/utf8_to_utf16_stream_decoder_unit.sv -----
// Top level of the UTF-8 to UTF-16 stream decoder: front, queue and back.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
//  channel | direction | fields                                        | handshake
//  s_      | in        | s_in_byte[7:0], s_last_byte                   | s_valid / s_ready
//  m_      | out       | m_utf16_word[15:0], m_word_valid, m_end_of_string | m_valid / m_ready
//
// One byte is accepted per cycle while the four-entry queue has room.
// The back sends one result beat per cycle while m_ready is high; a byte that gives two words
// (surrogate pair, or error word plus retried byte) takes two beats of the output port.
// A result passes through the queue and then the output register before it appears on the m_ channel.
// Reset clears the decoder state, the queue pointers and count, and the output valid flag.
// With m_ready low the queue fills and s_ready drops once it is full.
`timescale 1ns / 1ps

module utf8_to_utf16_stream_decoder_unit
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_utf16_word,
    output logic        m_word_valid,
    output logic        m_end_of_string
);

    queue_status_t q_status;
    entry_t        push_entry;
    entry_t        head;
    logic          push;
    logic          pop;

    u8u16_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    u8u16_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .q_status        (q_status),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_utf16_word    (m_utf16_word),
        .m_word_valid    (m_word_valid),
        .m_end_of_string (m_end_of_string)
    );

endmodule

// ----- src/u8u16_front.sv -----
// Front part: accepts UTF-8 bytes, tracks the pending sequence, builds queue entries.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          s_last_byte,
    input  queue_status_t q_status,
    output logic          push,
    output entry_t        push_entry
);

    localparam logic [20:0] MIN_TWO_CONT = 21'h00001F;
    localparam logic [20:0] MIN_ONE_CONT = 21'h00000F;

    typedef struct packed {
        logic        ok;
        logic [1:0]  pend;
        logic [20:0] code;
    } lead_t;

    function automatic lead_t lead_decode(input logic [7:0] c);
        lead_t r;
        r.ok   = 1'b1;
        r.pend = 2'd0;
        r.code = 21'd0;
        unique case (c) inside
            [8'h00:8'h7F]: begin
                r.code = {13'd0, c};
            end
            [8'hC2:8'hDF]: begin
                r.pend = 2'd1;
                r.code = {16'd0, c[4:0]};
            end
            [8'hE0:8'hEF]: begin
                r.pend = 2'd2;
                r.code = {17'd0, c[3:0]};
            end
            [8'hF0:8'hF7]: begin
                r.pend = 2'd3;
                r.code = {18'd0, c[2:0]};
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  pend_reg, pend_next;
    logic        stopped_reg, stopped_next;

    lead_t       lead;
    logic [20:0] cont_code;
    logic [20:0] supp;
    logic [1:0]  cont_np;
    logic        cont_fail;
    logic [1:0]  n_words;
    logic [15:0] w0, w1;
    logic        accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        lead      = lead_decode(s_in_byte);
        cont_code = {partial_reg[14:0], s_in_byte[5:0]};
        cont_np   = pend_reg - 2'd1;
        supp      = cont_code - SUPP_BASE;
        cont_fail = (s_in_byte[7:6] != 2'b10)
                 || (cont_np == 2'd1 && cont_code <= MIN_TWO_CONT)
                 || (cont_np == 2'd2 && cont_code <= MIN_ONE_CONT);
        n_words      = 2'd0;
        w0           = 16'd0;
        w1           = 16'd0;
        pend_next    = pend_reg;
        partial_next = partial_reg;
        stopped_next = stopped_reg;
        if (!stopped_reg) begin
            if (pend_reg != 2'd0) begin
                if (cont_fail) begin
                    // drop the sequence, then take the byte again as a lead
                    w0        = ERR_WORD;
                    n_words   = 2'd1;
                    pend_next = 2'd0;
                    if (!lead.ok) begin
                        w1      = ERR_WORD;
                        n_words = 2'd2;
                    end else if (lead.pend != 2'd0) begin
                        pend_next    = lead.pend;
                        partial_next = lead.code;
                    end else if (lead.code == 21'd0) begin
                        stopped_next = 1'b1;
                    end else begin
                        w1      = lead.code[15:0];
                        n_words = 2'd2;
                    end
                end else if (cont_np != 2'd0) begin
                    pend_next    = cont_np;
                    partial_next = cont_code;
                end else begin
                    pend_next    = 2'd0;
                    partial_next = cont_code;
                    if (cont_code >= SUPP_BASE) begin
                        w0      = {HI_SURR, supp[19:10]};
                        w1      = {LO_SURR, supp[9:0]};
                        n_words = 2'd2;
                    end else begin
                        w0      = cont_code[15:0];
                        n_words = 2'd1;
                    end
                end
            end else begin
                if (!lead.ok) begin
                    w0      = ERR_WORD;
                    n_words = 2'd1;
                end else if (lead.pend != 2'd0) begin
                    pend_next    = lead.pend;
                    partial_next = lead.code;
                end else if (lead.code == 21'd0) begin
                    stopped_next = 1'b1;
                end else begin
                    w0      = lead.code[15:0];
                    n_words = 2'd1;
                end
            end
        end
    end

    always_comb begin
        push_entry.word0  = w0;
        push_entry.word1  = w1;
        push_entry.valid0 = (n_words != 2'd0);
        push_entry.two    = (n_words == 2'd2);
        push_entry.eos    = s_last_byte;
        push              = accept && ((n_words != 2'd0) || s_last_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 21'd0;
            pend_reg    <= 2'd0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            if (s_last_byte) begin
                partial_reg <= 21'd0;
                pend_reg    <= 2'd0;
                stopped_reg <= 1'b0;
            end else begin
                partial_reg <= partial_next;
                pend_reg    <= pend_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

// ----- src/u8u16_queue.sv -----
// Short queue of result entries between the front and back parts.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;

    assign head         = mem[rd_ptr_reg];
    assign status.empty = (count_reg == QUEUE_CW'(0));
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

endmodule

// ----- src/u8u16_back.sv -----
// Back part: drains queue entries and sends one result beat per cycle while m_ready is high.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  entry_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_utf16_word,
    output logic          m_word_valid,
    output logic          m_end_of_string
);

    logic        out_valid_reg;
    logic [15:0] out_word_reg;
    logic        out_wvalid_reg;
    logic        out_eos_reg;
    logic        sec_pend_reg;
    logic [15:0] sec_word_reg;
    logic        sec_eos_reg;
    logic        load;

    assign load = !out_valid_reg || m_ready;
    assign pop  = load && !sec_pend_reg && !q_status.empty;

    assign m_valid         = out_valid_reg;
    assign m_utf16_word    = out_word_reg;
    assign m_word_valid    = out_wvalid_reg;
    assign m_end_of_string = out_eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sec_pend_reg  <= 1'b0;
        end else if (load) begin
            if (sec_pend_reg) begin
                out_valid_reg <= 1'b1;
                sec_pend_reg  <= 1'b0;
            end else if (!q_status.empty) begin
                out_valid_reg <= 1'b1;
                sec_pend_reg  <= head.two;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (sec_pend_reg) begin
                out_word_reg   <= sec_word_reg;
                out_wvalid_reg <= 1'b1;
                out_eos_reg    <= sec_eos_reg;
            end else if (!q_status.empty) begin
                out_word_reg   <= head.word0;
                out_wvalid_reg <= head.valid0;
                out_eos_reg    <= head.eos && !head.two;
                sec_word_reg   <= head.word1;
                sec_eos_reg    <= head.eos;
            end
        end
    end

endmodule

// ----- dv/tb_utf8_to_utf16_stream_decoder_unit.sv -----
// Self-checking bench for utf8_to_utf16_stream_decoder_unit: directed and random UTF-8 strings,
// predicted UTF-16 beats checked in order against the m_ channel under random back-pressure.
// Depends on u8u16_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream_decoder_unit;
    import u8u16_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 1600;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         drain;
    } feed_item_t;

    typedef struct {
        logic [15:0] word;
        logic        valid;
        logic        eos;
    } utf16_beat_t;

    localparam logic [8:0] OPENING [27] = '{
        9'h0DF, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F0, 9'h090, 9'h080, 9'h080,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h0C0, 9'h0E0, 9'h09F, 9'h0F0, 9'h08F, 9'h0C3, 9'h07F, 9'h080, 9'h1FF,
        9'h0E1, 9'h080, 9'h000, 9'h041, 9'h1FF
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_utf16_word;
    logic        m_word_valid;
    logic        m_end_of_string;

    feed_item_t  byte_feed[$];
    utf16_beat_t utf16_expected[$];

    logic [20:0] cp_acc = '0;
    logic [1:0]  conts_due = '0;
    logic        nul_hold = 1'b0;

    logic        in_beat = 1'b0;
    logic        out_beat = 1'b0;
    int          quiet = 0;
    logic        timed_out = 1'b0;
    int          errors = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;

    utf8_to_utf16_stream_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_utf16_word    (m_utf16_word),
        .m_word_valid    (m_word_valid),
        .m_end_of_string (m_end_of_string)
    );

    always #1 aclk = ~aclk;

    // Feed one byte into the partial code point; 0 on an invalid or overlong byte.
    function automatic bit absorb_octet(input logic [7:0] c);
        if (conts_due != 2'd0) begin
            if (c[7:6] != 2'b10) begin
                conts_due = 2'd0;
                return 1'b0;
            end
            cp_acc = {cp_acc[14:0], c[5:0]};
            conts_due = conts_due - 2'd1;
            if ((conts_due == 2'd1 && cp_acc <= 21'h1F) ||
                    (conts_due == 2'd2 && cp_acc <= 21'hF)) begin
                cp_acc = '0;
                conts_due = 2'd0;
                return 1'b0;
            end
            return 1'b1;
        end
        if (c[7] == 1'b0) begin
            cp_acc = {13'd0, c};
            return 1'b1;
        end
        if (c[7:5] == 3'b110) begin
            if (c[4:1] == 4'd0) begin
                cp_acc = '0;
                return 1'b0;
            end
            cp_acc = {16'd0, c[4:0]};
            conts_due = 2'd1;
            return 1'b1;
        end
        if (c[7:4] == 4'b1110) begin
            cp_acc = {17'd0, c[3:0]};
            conts_due = 2'd2;
            return 1'b1;
        end
        if (c[7:3] == 5'b11110) begin
            cp_acc = {18'd0, c[2:0]};
            conts_due = 2'd3;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_byte(input logic [7:0] c, input logic last);
        utf16_beat_t outs[$];
        bit          had_pending;
        bit          retry;
        logic [20:0] off;
        if (!nul_hold) begin
            for (int pass = 0; pass < 2; pass++) begin
                had_pending = (conts_due != 2'd0);
                retry = 1'b0;
                if (!absorb_octet(c)) begin
                    cp_acc = {5'd0, ERR_WORD};
                    conts_due = 2'd0;
                    retry = had_pending;
                end
                if (conts_due != 2'd0)
                    break;
                if (cp_acc == 21'd0) begin
                    nul_hold = 1'b1;
                    break;
                end
                if (cp_acc >= SUPP_BASE) begin
                    off = cp_acc - SUPP_BASE;
                    if (outs.size() == 0) begin
                        outs.push_back('{{HI_SURR, off[19:10]}, 1'b1, 1'b0});
                        outs.push_back('{{LO_SURR, off[9:0]}, 1'b1, 1'b0});
                    end
                end else if (outs.size() < 2) begin
                    outs.push_back('{cp_acc[15:0], 1'b1, 1'b0});
                end
                if (!retry)
                    break;
            end
        end
        if (last) begin
            if (outs.size() == 0)
                outs.push_back('{16'h0000, 1'b0, 1'b0});
            outs[outs.size() - 1].eos = 1'b1;
            cp_acc = '0;
            conts_due = 2'd0;
            nul_hold = 1'b0;
        end
        foreach (outs[i])
            utf16_expected.push_back(outs[i]);
    endtask

    function automatic byte_q_t encode_utf8(input logic [20:0] cp);
        byte_q_t q;
        if (cp < 21'h80) begin
            q.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            q.push_back({3'b110, cp[10:6]});
            q.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            q.push_back({4'b1110, cp[15:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
        end else begin
            q.push_back({5'b11110, cp[20:18]});
            q.push_back({2'b10, cp[17:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
        end
        return q;
    endfunction

    function automatic logic [20:0] pick_code_point(input int lo_class);
        case ($urandom_range(lo_class, 3))
            0: return 21'($urandom_range(1, 'h7F));
            1: return 21'($urandom_range('h80, 'h7FF));
            2: return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h1FFFFF));
        endcase
    endfunction

    // Mostly well-formed code points, with stray bytes, cut and overlong forms and NULs.
    task automatic queue_random_string(input bit drain);
        byte_q_t s;
        byte_q_t enc;
        int      kind;
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 99);
            enc = {};
            if (kind < 80) begin
                enc = encode_utf8(pick_code_point(0));
            end else if (kind < 88) begin
                enc.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 94) begin
                enc = encode_utf8(pick_code_point(1));
                repeat ($urandom_range(1, enc.size() - 1))
                    void'(enc.pop_back());
            end else if (kind < 98) begin
                case ($urandom_range(0, 2))
                    0: enc.push_back(8'($urandom_range('hC0, 'hC1)));
                    1: begin
                        enc.push_back(8'hE0);
                        enc.push_back(8'($urandom_range('h80, 'h9F)));
                    end
                    default: begin
                        enc.push_back(8'hF0);
                        enc.push_back(8'($urandom_range('h80, 'h8F)));
                    end
                endcase
                enc.push_back(8'($urandom_range('h80, 'hBF)));
            end else begin
                enc.push_back(8'h00);
            end
            foreach (enc[i])
                s.push_back(enc[i]);
        end
        foreach (s[i])
            byte_feed.push_back('{s[i], i == s.size() - 1, drain && i == 0});
    endtask

    function automatic int pick_gap(inout int calm_left);
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 4) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_beat) begin
                // hold the beat until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_feed.size() != 0 &&
                    !(byte_feed[0].drain && utf16_expected.size() != 0)) begin
                s_valid <= 1'b1;
                s_in_byte <= byte_feed[0].b;
                s_last_byte <= byte_feed[0].last;
                void'(byte_feed.pop_front());
                send_gap = pick_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (out_beat)
                    stall_left = pick_gap(stall_calm);
            end
        end
    end

    always @(posedge aclk) begin
        utf16_beat_t want;
        if (!aresetn) begin
            in_beat <= 1'b0;
            out_beat <= 1'b0;
            quiet <= 0;
        end else begin
            in_beat <= s_valid && s_ready;
            out_beat <= m_valid && m_ready;
            if (s_valid && s_ready)
                predict_byte(s_in_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (utf16_expected.size() == 0) begin
                    $display("%0t: unexpected beat word %h valid %b eos %b", $time,
                        m_utf16_word, m_word_valid, m_end_of_string);
                    errors++;
                end else begin
                    want = utf16_expected.pop_front();
                    if (m_utf16_word !== want.word) begin
                        $display("%0t: utf16_word expected %h, got %h", $time,
                            want.word, m_utf16_word);
                        errors++;
                    end
                    if (m_word_valid !== want.valid) begin
                        $display("%0t: word_valid expected %b, got %b", $time,
                            want.valid, m_word_valid);
                        errors++;
                    end
                    if (m_end_of_string !== want.eos) begin
                        $display("%0t: end_of_string expected %b, got %b", $time,
                            want.eos, m_end_of_string);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
                timed_out <= 1'b1;
            else
                quiet <= quiet + 1;
        end
    end

    initial begin
        int strings;
        strings = 0;
        foreach (OPENING[i])
            byte_feed.push_back('{OPENING[i][7:0], OPENING[i][8], 1'b0});
        while (byte_feed.size() < RANDOM_BYTES + $size(OPENING)) begin
            queue_random_string(strings % 50 == 0);
            strings++;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        while ((byte_feed.size() != 0 || s_valid) && !timed_out)
            @(negedge aclk);
        while (utf16_expected.size() != 0 && !timed_out)
            @(negedge aclk);
        if (!timed_out)
            repeat (20) @(negedge aclk);
        if (timed_out)
            $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        if (utf16_expected.size() != 0) begin
            $display("%0t: %0d beats never arrived, next expected word %h", $time,
                utf16_expected.size(), utf16_expected[0].word);
            errors++;
        end
        if (!timed_out && errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_stream_decoder_unit.sv
dv/tb_utf8_to_utf16_stream_decoder_unit.sv
